>>> rtl/core/sgpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgpg_pkg
// Shared types, constants and the 5x7 font ROM for the scaled glyph pixel
// generator.
// ----------------------------------------------------------------------------
package sgpg_pkg;

    localparam int MAX_WINDOW_WIDTH = 640;
    localparam int CELL_COLS        = 5;
    localparam int CELL_ROWS        = 7;
    localparam int ADVANCE_CELLS    = 6;

    localparam logic [9:0] WINDOW_WIDTH_RESET  = 10'd296;
    localparam logic [7:0] WINDOW_HEIGHT_RESET = 8'd8;

    // configuration register indexes
    localparam logic [0:0] CFG_WINDOW_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_WINDOW_HEIGHT = 1'b1;

    typedef struct packed {
        logic [7:0]         char_code;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [9:0]         pixel_x;
        logic [7:0]         pixel_y;
        logic [3:0]         scale;
        logic [7:0]         ink;
    } t_in_item;

    typedef struct packed {
        logic        write_enable;
        logic [17:0] pixel_address;
        logic [7:0]  ink_out;
        logic        glyph_known;
        logic [6:0]  advance;
    } t_out_item;

    typedef logic [0:CELL_COLS-1][7:0] t_cols;

    typedef struct packed {
        logic  known;
        t_cols cols;
    } t_glyph;

    // after stage 1: glyph fetched, offsets and row product formed
    typedef struct packed {
        logic        known;
        t_cols       cols;
        logic [16:0] dx;
        logic [16:0] dy;
        logic [3:0]  scale;
        logic        in_window;
        logic [17:0] product;
        logic [9:0]  pixel_x;
        logic [7:0]  ink;
        logic [6:0]  advance;
    } t_s1;

    // after stage 2: cell coordinates and final address
    typedef struct packed {
        logic        known;
        t_cols       cols;
        logic        in_cell;
        logic [2:0]  col;
        logic [2:0]  row;
        logic        in_window;
        logic [17:0] address;
        logic [7:0]  ink;
        logic [6:0]  advance;
    } t_s2;

    // column-major font, bit r of a column byte is row r (row 0 at top)
    function automatic t_glyph font_glyph(input logic [7:0] code);
        t_glyph g;
        g.known = 1'b1;
        case (code)
            8'h30: g.cols = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}; // 0
            8'h31: g.cols = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
            8'h32: g.cols = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
            8'h33: g.cols = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
            8'h34: g.cols = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
            8'h35: g.cols = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
            8'h36: g.cols = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
            8'h37: g.cols = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
            8'h38: g.cols = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
            8'h39: g.cols = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
            8'h2E: g.cols = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00}; // .
            8'h2C: g.cols = {8'h00, 8'h50, 8'h30, 8'h00, 8'h00}; // ,
            8'h2D: g.cols = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08}; // -
            8'h2F: g.cols = {8'h20, 8'h10, 8'h08, 8'h04, 8'h02}; // /
            8'h3A: g.cols = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00}; // :
            8'h20: g.cols = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00}; // space
            8'h24: g.cols = {8'h24, 8'h2A, 8'h7F, 8'h2A, 8'h12}; // $
            8'h41: g.cols = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}; // A
            8'h42: g.cols = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
            8'h43: g.cols = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
            8'h44: g.cols = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
            8'h45: g.cols = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
            8'h46: g.cols = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
            8'h47: g.cols = {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
            8'h48: g.cols = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
            8'h49: g.cols = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
            8'h4B: g.cols = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
            8'h4C: g.cols = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
            8'h4D: g.cols = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
            8'h4E: g.cols = {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
            8'h4F: g.cols = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
            8'h50: g.cols = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
            8'h52: g.cols = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
            8'h53: g.cols = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
            8'h54: g.cols = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
            8'h55: g.cols = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
            8'h56: g.cols = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
            8'h57: g.cols = {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
            8'h58: g.cols = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
            8'h59: g.cols = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
            8'h5A: g.cols = {8'h61, 8'h51, 8'h49, 8'h45, 8'h43}; // Z
            default: begin
                g.known = 1'b0;
                g.cols  = '0;
            end
        endcase
        return g;
    endfunction

endpackage

>>> rtl/core/sgpg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgpg_front
// Stage 1: font lookup, glyph-relative offsets, window clip and row product.
// ----------------------------------------------------------------------------
module sgpg_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sgpg_pkg::t_in_item  i_item,
    input  logic [9:0]          i_window_width,
    input  logic [7:0]          i_window_height,
    output logic                o_valid,
    input  logic                i_ready,
    output sgpg_pkg::t_s1       o_stage
);

    logic             r_valid;
    sgpg_pkg::t_s1    r_stage;
    sgpg_pkg::t_s1    n_stage;
    sgpg_pkg::t_glyph glyph;
    logic [9:0]       stride;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        // oversized window saturates for both clip and stride
        if ({1'b0, i_window_width} > 11'(sgpg_pkg::MAX_WINDOW_WIDTH)) begin
            stride = 10'(sgpg_pkg::MAX_WINDOW_WIDTH);
        end else begin
            stride = i_window_width;
        end
        glyph             = sgpg_pkg::font_glyph(i_item.char_code);
        n_stage.known     = glyph.known;
        n_stage.cols      = glyph.cols;
        n_stage.dx        = {7'b0, i_item.pixel_x} - {i_item.origin_x[15], i_item.origin_x};
        n_stage.dy        = {9'b0, i_item.pixel_y} - {i_item.origin_y[15], i_item.origin_y};
        n_stage.scale     = i_item.scale;
        n_stage.in_window = (i_item.pixel_x < stride) && (i_item.pixel_y < i_window_height);
        n_stage.product   = {10'b0, i_item.pixel_y} * {8'b0, stride};
        n_stage.pixel_x   = i_item.pixel_x;
        n_stage.ink       = i_item.ink;
        n_stage.advance   = {3'b0, i_item.scale} * 7'(sgpg_pkg::ADVANCE_CELLS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

>>> rtl/core/sgpg_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgpg_cell
// Stage 2: glyph bounds test, font cell column and row, pixel address.
// ----------------------------------------------------------------------------
module sgpg_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sgpg_pkg::t_s1 i_stage,
    output logic          o_valid,
    input  logic          i_ready,
    output sgpg_pkg::t_s2 o_stage
);

    logic          r_valid;
    sgpg_pkg::t_s2 r_stage;
    sgpg_pkg::t_s2 n_stage;
    logic [6:0]    lim_x;
    logic [6:0]    lim_y;
    logic [6:0]    step;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        lim_x = {3'b0, i_stage.scale} * 7'(sgpg_pkg::CELL_COLS);
        lim_y = {3'b0, i_stage.scale} * 7'(sgpg_pkg::CELL_ROWS);

        n_stage.known   = i_stage.known;
        n_stage.cols    = i_stage.cols;
        n_stage.in_cell = i_stage.known && (i_stage.scale != 4'd0)
                          && !i_stage.dx[16] && !i_stage.dy[16]
                          && (i_stage.dx < {10'b0, lim_x})
                          && (i_stage.dy < {10'b0, lim_y});

        // offset / scale as a count of crossed multiples; in-cell offsets stay below 7 bits
        n_stage.col = 3'd0;
        for (int k = 1; k < sgpg_pkg::CELL_COLS; k++) begin
            step = 7'(k) * {3'b0, i_stage.scale};
            if (i_stage.dx[6:0] >= step) begin
                n_stage.col = n_stage.col + 3'd1;
            end
        end
        n_stage.row = 3'd0;
        for (int k = 1; k < sgpg_pkg::CELL_ROWS; k++) begin
            step = 7'(k) * {3'b0, i_stage.scale};
            if (i_stage.dy[6:0] >= step) begin
                n_stage.row = n_stage.row + 3'd1;
            end
        end

        n_stage.in_window = i_stage.in_window;
        n_stage.address   = i_stage.product + {8'b0, i_stage.pixel_x};
        n_stage.ink       = i_stage.ink;
        n_stage.advance   = i_stage.advance;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

>>> rtl/core/sgpg_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgpg_out
// Stage 3: font bit select, write enable and the output register.
// ----------------------------------------------------------------------------
module sgpg_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sgpg_pkg::t_s2       i_stage,
    output logic                o_valid,
    input  logic                i_ready,
    output sgpg_pkg::t_out_item o_item
);

    logic                r_valid;
    sgpg_pkg::t_out_item r_item;
    sgpg_pkg::t_out_item n_item;
    logic                lit;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        lit                  = i_stage.in_cell && i_stage.cols[i_stage.col][i_stage.row];
        n_item.write_enable  = lit && i_stage.in_window;
        n_item.pixel_address = i_stage.address;
        n_item.ink_out       = (lit && i_stage.in_window) ? i_stage.ink : 8'd0;
        n_item.glyph_known   = i_stage.known;
        n_item.advance       = i_stage.advance;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> rtl/core/scaled_glyph_pixel_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_glyph_pixel_generator
// Per-pixel 5x7 character generator with integer scale and window clipping.
// ----------------------------------------------------------------------------
// Three register stages (front, cell, out) lie between input accept and result valid.
// Throughput: one item per cycle while the output is ready; a stalled output holds each stage in place.
// Reset (synchronous, active low): all stage valid bits cleared, window
// width back to 296 and window height back to 8. No memories to clear.
module scaled_glyph_pixel_generator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sgpg_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sgpg_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_index,
    input  logic [9:0]          i_cfg_data
);

    logic [9:0]    r_window_width;
    logic [7:0]    r_window_height;

    logic          s1_valid;
    logic          s1_ready;
    sgpg_pkg::t_s1 s1_stage;
    logic          s2_valid;
    logic          s2_ready;
    sgpg_pkg::t_s2 s2_stage;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_width  <= sgpg_pkg::WINDOW_WIDTH_RESET;
            r_window_height <= sgpg_pkg::WINDOW_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == sgpg_pkg::CFG_WINDOW_WIDTH) begin
                r_window_width <= i_cfg_data;
            end
            if (i_cfg_index == sgpg_pkg::CFG_WINDOW_HEIGHT) begin
                r_window_height <= i_cfg_data[7:0];
            end
        end
    end

    sgpg_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_ready         (o_in_ready),
        .i_item          (i_in_item),
        .i_window_width  (r_window_width),
        .i_window_height (r_window_height),
        .o_valid         (s1_valid),
        .i_ready         (s1_ready),
        .o_stage         (s1_stage)
    );

    sgpg_cell u_cell (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_stage (s1_stage),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_stage (s2_stage)
    );

    sgpg_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_stage (s2_stage),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

    // input back-pressure only when every stage holds an item
    a_full_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (s1_valid && s2_valid && o_out_valid))
        else $error("input stalled with a free pipeline stage");

    a_write_needs_glyph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.write_enable)
            |-> (o_out_item.glyph_known && o_out_item.advance != 7'd0))
        else $error("write enable without a known glyph");

    a_ink_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.write_enable) |-> (o_out_item.ink_out == 8'd0))
        else $error("ink given for an unwritten pixel");

    // a stage that waits on its successor keeps its item
    a_s2_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_valid && !s2_ready) |=> (s2_valid && $stable(s2_stage)))
        else $error("stage 2 item lost under stall");

endmodule

>>> sim/sgpg_pixel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgpg_pixel_checker
// Watches the item, result and register ports of the scaled glyph pixel
// generator, predicts each pixel result from its own font table and window
// copy, and compares every result with the oldest pending prediction.
// ----------------------------------------------------------------------------
module sgpg_pixel_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  sgpg_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  sgpg_pkg::t_out_item i_out_item,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_index,
    input  logic [9:0]          i_cfg_data,
    output int                  o_pending,
    output int                  o_fail_count
);

    // code in [47:40], then column 0 .. column 4, one byte each
    logic [47:0] glyph_table [41] = '{
        48'h30_3E_51_49_45_3E, 48'h31_00_42_7F_40_00, 48'h32_42_61_51_49_46,
        48'h33_21_41_45_4B_31, 48'h34_18_14_12_7F_10, 48'h35_27_45_45_45_39,
        48'h36_3C_4A_49_49_30, 48'h37_01_71_09_05_03, 48'h38_36_49_49_49_36,
        48'h39_06_49_49_29_1E, 48'h2E_00_60_60_00_00, 48'h2C_00_50_30_00_00,
        48'h2D_08_08_08_08_08, 48'h2F_20_10_08_04_02, 48'h3A_00_36_36_00_00,
        48'h20_00_00_00_00_00, 48'h24_24_2A_7F_2A_12, 48'h41_7E_11_11_11_7E,
        48'h42_7F_49_49_49_36, 48'h43_3E_41_41_41_22, 48'h44_7F_41_41_22_1C,
        48'h45_7F_49_49_49_41, 48'h46_7F_09_09_09_01, 48'h47_3E_41_49_49_7A,
        48'h48_7F_08_08_08_7F, 48'h49_00_41_7F_41_00, 48'h4B_7F_08_14_22_41,
        48'h4C_7F_40_40_40_40, 48'h4D_7F_02_0C_02_7F, 48'h4E_7F_04_08_10_7F,
        48'h4F_3E_41_41_41_3E, 48'h50_7F_09_09_09_06, 48'h52_7F_09_19_29_46,
        48'h53_46_49_49_49_31, 48'h54_01_01_7F_01_01, 48'h55_3F_40_40_40_3F,
        48'h56_1F_20_40_20_1F, 48'h57_3F_40_38_40_3F, 48'h58_63_14_08_14_63,
        48'h59_07_08_70_08_07, 48'h5A_61_51_49_45_43
    };

    int                  win_w = int'(sgpg_pkg::WINDOW_WIDTH_RESET);
    int                  win_h = int'(sgpg_pkg::WINDOW_HEIGHT_RESET);
    sgpg_pkg::t_out_item expected_pixels [$];

    function automatic sgpg_pkg::t_out_item predict_pixel(input sgpg_pkg::t_in_item q,
                                                          input int ww, input int wh);
        sgpg_pkg::t_out_item r;
        logic [39:0]         cols;
        logic                known;
        logic                lit;
        logic                in_window;
        int                  k;
        int                  stride;
        int                  sc;
        int                  dx;
        int                  dy;
        int                  col;
        int                  row;
        int                  addr;
        int                  adv;
        known = 1'b0;
        cols  = '0;
        for (k = 0; k < 41; k++) begin
            if (glyph_table[k][47:40] == q.char_code) begin
                known = 1'b1;
                cols  = glyph_table[k][39:0];
            end
        end
        stride = (ww > sgpg_pkg::MAX_WINDOW_WIDTH) ? sgpg_pkg::MAX_WINDOW_WIDTH : ww;
        in_window = (int'(q.pixel_x) < stride) && (int'(q.pixel_y) < wh);
        sc     = int'(q.scale);
        dx     = int'(q.pixel_x) - int'($signed(q.origin_x));
        dy     = int'(q.pixel_y) - int'($signed(q.origin_y));
        lit    = 1'b0;
        if (known && sc != 0 && dx >= 0 && dy >= 0 &&
            dx < sgpg_pkg::CELL_COLS * sc && dy < sgpg_pkg::CELL_ROWS * sc) begin
            col = dx / sc;
            row = dy / sc;
            // byte of column c sits with its lsb at bit 32 - 8c
            lit = cols[32 - 8 * col + row];
        end
        addr            = int'(q.pixel_y) * stride + int'(q.pixel_x);
        adv             = sgpg_pkg::ADVANCE_CELLS * sc;
        r.write_enable  = lit && in_window;
        r.pixel_address = addr[17:0];
        r.ink_out       = (lit && in_window) ? q.ink : 8'h00;
        r.glyph_known   = known;
        r.advance       = adv[6:0];
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        sgpg_pkg::t_out_item want;
        int                  nerr;
        nerr = 0;
        if (!i_rst_n) begin
            win_w = int'(sgpg_pkg::WINDOW_WIDTH_RESET);
            win_h = int'(sgpg_pkg::WINDOW_HEIGHT_RESET);
            expected_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sgpg_pkg::CFG_WINDOW_WIDTH:  win_w = int'(i_cfg_data);
                    sgpg_pkg::CFG_WINDOW_HEIGHT: win_h = int'(i_cfg_data[7:0]);
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("result item with no pending prediction");
                    nerr++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_out_item.write_enable !== want.write_enable) begin
                        $error("write_enable: expected %0d, got %0d",
                               want.write_enable, i_out_item.write_enable);
                        nerr++;
                    end
                    if (i_out_item.pixel_address !== want.pixel_address) begin
                        $error("pixel_address: expected %0d, got %0d",
                               want.pixel_address, i_out_item.pixel_address);
                        nerr++;
                    end
                    if (i_out_item.ink_out !== want.ink_out) begin
                        $error("ink_out: expected %0d, got %0d",
                               want.ink_out, i_out_item.ink_out);
                        nerr++;
                    end
                    if (i_out_item.glyph_known !== want.glyph_known) begin
                        $error("glyph_known: expected %0d, got %0d",
                               want.glyph_known, i_out_item.glyph_known);
                        nerr++;
                    end
                    if (i_out_item.advance !== want.advance) begin
                        $error("advance: expected %0d, got %0d",
                               want.advance, i_out_item.advance);
                        nerr++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_pixels.push_back(predict_pixel(i_in_item, win_w, win_h));
        end
        o_pending    <= expected_pixels.size();
        o_fail_count <= o_fail_count + nerr;
    end

endmodule

>>> sim/tb_scaled_glyph_pixel_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scaled_glyph_pixel_generator
// Drives pixel queries into the glyph generator under random gaps and output
// stalls, across a series of window settings including saturated and empty
// windows; the pixel checker predicts and compares, this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_scaled_glyph_pixel_generator;

    localparam int PHASE_ITEMS = 80;
    localparam int NUM_PHASES  = 10;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                in_valid     = 1'b0;
    sgpg_pkg::t_in_item  in_item      = '0;
    logic                out_ready    = 1'b0;
    logic                cfg_we       = 1'b0;
    logic [0:0]          cfg_index    = sgpg_pkg::CFG_WINDOW_WIDTH;
    logic [9:0]          cfg_data     = '0;
    logic                in_ready;
    logic                out_valid;
    sgpg_pkg::t_out_item out_item;
    int                  pending;
    int                  fail_count;
    int                  queries_sent = 0;
    logic                send_burst   = 1'b0;
    logic                drain_burst  = 1'b0;

    string known_chars = "0123456789.,-/: $ABCDEFGHIKLMNOPRSTUVWXYZ";

    // window settings per phase; the last phase draws its own
    int phase_w [NUM_PHASES] = '{640, 1, 0, 700, 1023, 100, 320, 37, 296, 0};
    int phase_h [NUM_PHASES] = '{255, 1, 20, 30, 0, 50, 240, 255, 8, 0};

    scaled_glyph_pixel_generator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    sgpg_pixel_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // result side: random stalls with stretches of none
    initial begin : drain_side
        int stall;
        forever begin
            if ($urandom_range(0, 39) == 0)
                drain_burst = ~drain_burst;
            stall = drain_burst ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!(out_valid && out_ready));
        end
    end

    function automatic sgpg_pkg::t_in_item mk_pixel(input logic [7:0] code, input int ox,
                                                    input int oy, input int px, input int py,
                                                    input int sc, input int ink);
        sgpg_pkg::t_in_item q;
        q.char_code = code;
        q.origin_x  = 16'(ox);
        q.origin_y  = 16'(oy);
        q.pixel_x   = 10'(px);
        q.pixel_y   = 8'(py);
        q.scale     = 4'(sc);
        q.ink       = 8'(ink);
        return q;
    endfunction

    // mostly queries that land in or just around a glyph box
    function automatic sgpg_pkg::t_in_item rand_pixel(input int ww, input int wh);
        sgpg_pkg::t_in_item q;
        int                 kind;
        int                 span_x;
        int                 span_y;
        int                 px;
        int                 py;
        int                 sc;
        int                 dx;
        int                 dy;
        int                 ox;
        int                 oy;
        kind   = $urandom_range(0, 99);
        span_x = (ww > 640) ? 640 : ww;
        if (span_x == 0 || $urandom_range(0, 4) == 0)
            span_x = 640;
        span_y = wh;
        if (span_y == 0 || $urandom_range(0, 4) == 0)
            span_y = 255;
        px = $urandom_range(0, span_x - 1);
        py = $urandom_range(0, span_y - 1);
        q.ink = 8'($urandom_range(0, 255));
        if (kind < 15) begin
            q.char_code = 8'($urandom_range(0, 255));
            q.origin_x  = 16'($urandom);
            q.origin_y  = 16'($urandom);
            q.scale     = 4'($urandom_range(0, 15));
            q.pixel_x   = 10'($urandom_range(0, 639));
            q.pixel_y   = 8'($urandom_range(0, 254));
        end else begin
            if (kind < 85)
                q.char_code = known_chars[$urandom_range(0, 40)];
            else
                q.char_code = 8'($urandom_range(0, 255));
            sc = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 15) : $urandom_range(1, 4);
            if ($urandom_range(0, 19) == 0)
                sc = 0;
            // one pixel either side of the box edge now and then
            dx = $urandom_range(0, 5 * sc + 1) - 1;
            dy = $urandom_range(0, 7 * sc + 1) - 1;
            ox = px - dx;
            oy = py - dy;
            q.origin_x = 16'(ox);
            q.origin_y = 16'(oy);
            q.scale    = 4'(sc);
            q.pixel_x  = 10'(px);
            q.pixel_y  = 8'(py);
        end
        return q;
    endfunction

    task automatic send_pixel(input sgpg_pkg::t_in_item q);
        int gap;
        if ($urandom_range(0, 49) == 0)
            send_burst = ~send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= q;
        do @(posedge i_clk); while (!(in_valid && in_ready));
        queries_sent++;
    endtask

    // hold off until every predicted result has come back
    task automatic wait_drained();
        int cycles;
        cycles = 0;
        in_valid <= 1'b0;
        // let the checker register its pending count first so that it includes the item just accepted
        @(posedge i_clk);
        while (pending != 0 && cycles < 2000) begin
            @(posedge i_clk);
            cycles++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    // leaves the write enable high; the caller drops it after its last write
    task automatic write_reg(input logic [0:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 10'(value);
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        int ph;
        int n;
        int ww;
        int wh;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset window 296 x 8
        send_pixel(mk_pixel(8'h30, 0, 0, 1, 0, 1, 255));
        send_pixel(mk_pixel(8'h30, 0, 0, 0, 0, 1, 255));
        send_pixel(mk_pixel(8'h41, 0, 0, 0, 1, 1, 0));
        send_pixel(mk_pixel(8'h41, 10, 0, 24, 7, 3, 170));
        send_pixel(mk_pixel(8'h42, 0, -100, 74, 4, 15, 85));
        send_pixel(mk_pixel(8'h48, 0, 0, 0, 0, 0, 255));      // zero scale
        send_pixel(mk_pixel(8'h51, 0, 0, 0, 0, 1, 255));      // not in font
        send_pixel(mk_pixel(8'hFF, 0, 0, 0, 0, 1, 255));
        send_pixel(mk_pixel(8'h00, 0, 0, 0, 0, 1, 255));
        send_pixel(mk_pixel(8'h4C, 291, 1, 295, 7, 1, 255));  // last column in window
        send_pixel(mk_pixel(8'h4C, 292, 1, 296, 7, 1, 255));  // lit but clipped
        send_pixel(mk_pixel(8'h2D, -32768, -32768, 639, 254, 15, 255));
        send_pixel(mk_pixel(8'h2D, 32767, 32767, 0, 0, 15, 255));
        send_pixel(mk_pixel(8'h24, -2, -3, 0, 0, 1, 1));
        send_pixel(mk_pixel(8'h20, 0, 0, 2, 3, 1, 255));
        send_pixel(mk_pixel(8'h5A, 620, 240, 639, 254, 4, 200));
        wait_drained();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            ww = phase_w[ph];
            wh = phase_h[ph];
            if (ph == NUM_PHASES - 1) begin
                ww = $urandom_range(1, 640);
                wh = $urandom_range(1, 255);
            end
            write_reg(sgpg_pkg::CFG_WINDOW_WIDTH, ww);
            write_reg(sgpg_pkg::CFG_WINDOW_HEIGHT, wh);
            cfg_we <= 1'b0;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                send_pixel(rand_pixel(ww, wh));
                if (ph == 3 && n == PHASE_ITEMS / 2)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        $display("%0d pixel queries checked over %0d window settings,", queries_sent,
                 NUM_PHASES + 1);
        $display("zero, saturated and full-size windows among them");
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> scaled_glyph_pixel_generator.f
rtl/core/sgpg_pkg.sv
rtl/core/sgpg_front.sv
rtl/core/sgpg_cell.sv
rtl/core/sgpg_out.sv
rtl/core/scaled_glyph_pixel_generator.sv
sim/sgpg_pixel_checker.sv
sim/tb_scaled_glyph_pixel_generator.sv
